/* hw/rtl/input_event_mapper_dblclick_assert.svh */
// ----------------------------------------------------------------------------
// input_event_mapper_dblclick assertion macros
// Implication checks on the block clock, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef INPUT_EVENT_MAPPER_DBLCLICK_ASSERT_SVH
`define INPUT_EVENT_MAPPER_DBLCLICK_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define IEMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IEMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define IEMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define IEMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/iemd_pkg.sv */
// ----------------------------------------------------------------------------
// iemd_pkg
// Shared types and constants of the input event mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package iemd_pkg;

	// field widths
	localparam int OP_W       = 3;
	localparam int KEY_CODE_W = 10;
	localparam int DELTA_W    = 16;
	localparam int MOVE_W     = 23;
	localparam int SENS_W     = 10;
	localparam int TICK_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int MMASK_W    = 3;
	localparam int JMASK_W    = 6;

	// event kinds
	localparam logic [OP_W-1:0] OP_KEY_DOWN = 3'd0;
	localparam logic [OP_W-1:0] OP_KEY_UP   = 3'd1;
	localparam logic [OP_W-1:0] OP_MOUSE    = 3'd2;
	localparam logic [OP_W-1:0] OP_JOY      = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK     = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_SENS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOK_SENS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP  = 2'd2;

	localparam logic [SENS_W-1:0] SENS_RESET = 10'd10;
	localparam logic [TICK_W-1:0] TICK_RESET = 4'd1;

	// scaling: |d| * (sens + 1) fits 26 bits, then divide by 10
	localparam int SCALE_DIV   = 10;
	localparam int PROD_W      = 26;
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W     = 27;
	localparam int QUOT_W      = 22;
	localparam logic [RECIP_W-1:0] RECIP_K =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SCALE_DIV - 1)) / 64'(SCALE_DIV));

	// double-click detector
	localparam int TIMER_W = 8;
	localparam int CLICK_W = 2;
	localparam logic [TIMER_W-1:0] TIMER_MAX         = 8'd255;
	localparam logic [TIMER_W-1:0] TIMER_LIMIT       = 8'd20;
	localparam logic [CLICK_W-1:0] CLICKS_FOR_DOUBLE = 2'd2;

	typedef struct packed {
		logic [TIMER_W-1:0] timer;
		logic               level;
		logic [CLICK_W-1:0] count;
	} det_state_t;

endpackage

`default_nettype wire

/* hw/rtl/iemd_if.sv */
// ----------------------------------------------------------------------------
// iemd channel interfaces
// Event, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface iemd_evt_if
	import iemd_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic [KEY_CODE_W-1:0]     key_code;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;

	modport source (output valid, operation, key_code, delta_x, delta_y, input ready);
	modport sink   (input valid, operation, key_code, delta_x, delta_y, output ready);
endinterface

interface iemd_res_if
	import iemd_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [MOVE_W-1:0]  mouse_move_x;
	logic signed [MOVE_W-1:0]  mouse_move_y;
	logic signed [MOVE_W-1:0]  look_move_y;
	logic signed [DELTA_W-1:0] joy_pos_x;
	logic signed [DELTA_W-1:0] joy_pos_y;
	logic [MMASK_W-1:0]        mouse_double_mask;
	logic [JMASK_W-1:0]        joy_double_mask;
	logic                      key_pressed;

	modport source (output valid, mouse_move_x, mouse_move_y, look_move_y, joy_pos_x,
		joy_pos_y, mouse_double_mask, joy_double_mask, key_pressed, input ready);
	modport sink   (input valid, mouse_move_x, mouse_move_y, look_move_y, joy_pos_x,
		joy_pos_y, mouse_double_mask, joy_double_mask, key_pressed, output ready);
endinterface

interface iemd_cfg_if
	import iemd_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/iemd_click_det.sv */
// ----------------------------------------------------------------------------
// iemd_click_det
// Double-click detector for one button: saturating timer, level, click count.
// ----------------------------------------------------------------------------
`default_nettype none

module iemd_click_det
	import iemd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              level,
	input  wire logic [TICK_W-1:0] step,
	output logic                   dbl
);

	det_state_t         st_q;
	det_state_t         st_d;
	logic [CLICK_W-1:0] cnt_inc;
	logic [TIMER_W:0]   t_sum;

	always_comb begin
		st_d    = st_q;
		dbl     = 1'b0;
		cnt_inc = level ? st_q.count + 2'd1 : st_q.count;
		t_sum   = {1'b0, st_q.timer} + {{(TIMER_W + 1 - TICK_W){1'b0}}, step};
		if (level != st_q.level && st_q.timer > TIMER_W'(1)) begin
			st_d.level = level;
			if (cnt_inc == CLICKS_FOR_DOUBLE) begin
				// second click: timer holds its value
				st_d.count = '0;
				dbl        = 1'b1;
			end else begin
				st_d.count = cnt_inc;
				st_d.timer = '0;
			end
		end else begin
			st_d.timer = (t_sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : t_sum[TIMER_W-1:0];
			if (st_d.timer > TIMER_LIMIT) begin
				st_d.count = '0;
				st_d.level = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q <= st_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/input_event_mapper_dblclick.sv */
// An accepted event passes the stage 1, stage 2 and result registers to res. Throughput: one
// event per cycle unless clearing or a full pipe behind a stalled res holds evt.ready low;
// per-stage ready lets input flow while a result waits. Speed is set by the two multiplier
// stages (sensitivity product, divide by ten). Reset clears the control state; the key store then
// clears all KEY_CODES entries (512 by default) with evt.ready low. Register writes are taken at any time.
`default_nettype none

`include "input_event_mapper_dblclick_assert.svh"

// ----------------------------------------------------------------------------
// input_event_mapper_dblclick
// Key store, scaled mouse and joystick hold, per-button double-click masks.
// ----------------------------------------------------------------------------
module input_event_mapper_dblclick
	import iemd_pkg::*;
#(
	parameter int KEY_CODES      = 512,
	parameter int MOUSE_BUTTONS  = 3,
	parameter int JOY_BUTTONS    = 6,
	parameter int MOUSE_KEY_BASE = 256,
	parameter int JOY_KEY_BASE   = 272
) (
	input wire logic clk,
	input wire logic arst_n,
	iemd_cfg_if.sink   cfg,
	iemd_evt_if.sink   evt,
	iemd_res_if.source res
);

	localparam int KEY_AW = $clog2(KEY_CODES);
	localparam int CLR_W  = $clog2(KEY_CODES + 1);
	localparam int DET    = MOUSE_BUTTONS + JOY_BUTTONS;

	// configuration
	logic [SENS_W-1:0] mouse_sens_q;
	logic [SENS_W-1:0] look_sens_q;
	logic [TICK_W-1:0] tick_step_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mouse_sens_q <= SENS_RESET;
			look_sens_q  <= SENS_RESET;
			tick_step_q  <= TICK_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MOUSE_SENS: mouse_sens_q <= cfg.data[SENS_W-1:0];
				CFG_LOOK_SENS:  look_sens_q  <= cfg.data[SENS_W-1:0];
				CFG_TICK_STEP:  tick_step_q  <= cfg.data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline handshake
	logic s1_valid_q, s2_valid_q, out_valid_q;
	logic out_adv, s2_free, s1_free, clearing, accept;

	assign out_adv   = !out_valid_q || res.ready;
	assign s2_free   = !s2_valid_q || out_adv;
	assign s1_free   = !s1_valid_q || s2_free;
	assign evt.ready = !clearing && s1_free;
	assign accept    = evt.valid && evt.ready;
	assign res.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) s1_valid_q <= accept;
			if (s2_free) s2_valid_q <= s1_valid_q;
			if (out_adv) out_valid_q <= s2_valid_q;
		end
	end

	// event decode
	logic evt_is_key, evt_is_mouse, evt_is_joy, evt_in_rng, evt_down, key_wr;

	always_comb begin
		evt_is_key   = 1'b0;
		evt_is_mouse = 1'b0;
		evt_is_joy   = 1'b0;
		unique case (evt.operation) inside
			OP_KEY_DOWN, OP_KEY_UP: evt_is_key   = 1'b1;
			OP_MOUSE:               evt_is_mouse = 1'b1;
			OP_JOY:                 evt_is_joy   = 1'b1;
			default: ;  // tick and unused codes
		endcase
	end

	assign evt_in_rng = 32'(evt.key_code) < KEY_CODES;
	assign evt_down   = evt.operation == OP_KEY_DOWN;
	assign key_wr     = accept && evt_is_key && evt_in_rng;

	// key store with clearing pass after reset
	logic [CLR_W-1:0]  clr_cnt_q;
	logic              key_mem [KEY_CODES];
	logic              mem_we, mem_wdata;
	logic [KEY_AW-1:0] mem_waddr;
	logic              key_rd_s1;

	assign clearing  = clr_cnt_q != CLR_W'(KEY_CODES);
	assign mem_we    = clearing || key_wr;
	assign mem_waddr = clearing ? clr_cnt_q[KEY_AW-1:0] : evt.key_code[KEY_AW-1:0];
	assign mem_wdata = !clearing && evt_down;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= clr_cnt_q + CLR_W'(1);
		end
	end

	// read-first: key ops take their bit from the decode instead
	always_ff @(posedge clk) begin
		if (mem_we) key_mem[mem_waddr] <= mem_wdata;
		if (accept) key_rd_s1 <= key_mem[evt.key_code[KEY_AW-1:0]];
	end

	// button bits mirrored in flops so every detector sees its own level
	logic [DET-1:0] btn_down_q;

	for (genvar i = 0; i < DET; i++) begin : g_btn
		localparam int BTN_CODE = (i < MOUSE_BUTTONS) ? MOUSE_KEY_BASE + i
			: JOY_KEY_BASE + i - MOUSE_BUTTONS;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				btn_down_q[i] <= 1'b0;
			end else if (key_wr && 32'(evt.key_code) == BTN_CODE) begin
				btn_down_q[i] <= evt_down;
			end
		end
	end

	// stage 1
	logic                      is_key_s1, key_val_s1, in_rng_s1, is_mouse_s1, is_joy_s1;
	logic [DELTA_W-1:0]        mag_x_s1, mag_y_s1;
	logic                      neg_x_s1, neg_y_s1;
	logic signed [DELTA_W-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			is_key_s1   <= evt_is_key;
			key_val_s1  <= evt_down;
			in_rng_s1   <= evt_in_rng;
			is_mouse_s1 <= evt_is_mouse;
			is_joy_s1   <= evt_is_joy;
			neg_x_s1    <= evt.delta_x[DELTA_W-1];
			neg_y_s1    <= evt.delta_y[DELTA_W-1];
			mag_x_s1    <= evt.delta_x[DELTA_W-1] ? DELTA_W'(-evt.delta_x) : evt.delta_x;
			mag_y_s1    <= evt.delta_y[DELTA_W-1] ? DELTA_W'(-evt.delta_y) : evt.delta_y;
			dx_s1       <= evt.delta_x;
			dy_s1       <= evt.delta_y;
		end
	end

	logic [SENS_W:0]          ms_p1, ls_p1;
	logic [DELTA_W+SENS_W:0]  pf_mx, pf_my, pf_ly;
	logic                     kp_s1;
	logic [DET-1:0]           dbl_s1;
	logic                     det_en;

	assign ms_p1 = {1'b0, mouse_sens_q} + (SENS_W + 1)'(1);
	assign ls_p1 = {1'b0, look_sens_q} + (SENS_W + 1)'(1);
	assign pf_mx = {{(SENS_W + 1){1'b0}}, mag_x_s1} * {{DELTA_W{1'b0}}, ms_p1};
	assign pf_my = {{(SENS_W + 1){1'b0}}, mag_y_s1} * {{DELTA_W{1'b0}}, ms_p1};
	assign pf_ly = {{(SENS_W + 1){1'b0}}, mag_y_s1} * {{DELTA_W{1'b0}}, ls_p1};
	assign kp_s1 = in_rng_s1 && (is_key_s1 ? key_val_s1 : key_rd_s1);

	// detectors step once per event, as it leaves stage 1
	assign det_en = s1_valid_q && s2_free;

	for (genvar i = 0; i < DET; i++) begin : g_det
		iemd_click_det u_det (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (det_en),
			.level  (btn_down_q[i]),
			.step   (tick_step_q),
			.dbl    (dbl_s1[i])
		);
	end

	logic [MMASK_W-1:0] mmask_s1;
	logic [JMASK_W-1:0] jmask_s1;

	for (genvar j = 0; j < MMASK_W; j++) begin : g_mmask
		if (j < MOUSE_BUTTONS) begin : g_on
			assign mmask_s1[j] = dbl_s1[j];
		end else begin : g_off
			assign mmask_s1[j] = 1'b0;
		end
	end

	for (genvar j = 0; j < JMASK_W; j++) begin : g_jmask
		if (j < JOY_BUTTONS) begin : g_on
			assign jmask_s1[j] = dbl_s1[MOUSE_BUTTONS + j];
		end else begin : g_off
			assign jmask_s1[j] = 1'b0;
		end
	end

	// stage 2
	logic [PROD_W-1:0]         prod_mx_s2, prod_my_s2, prod_ly_s2;
	logic                      neg_x_s2, neg_y_s2, is_mouse_s2, is_joy_s2, kp_s2;
	logic signed [DELTA_W-1:0] dx_s2, dy_s2;
	logic [MMASK_W-1:0]        mmask_s2;
	logic [JMASK_W-1:0]        jmask_s2;

	always_ff @(posedge clk) begin
		if (s2_free) begin
			prod_mx_s2  <= pf_mx[PROD_W-1:0];
			prod_my_s2  <= pf_my[PROD_W-1:0];
			prod_ly_s2  <= pf_ly[PROD_W-1:0];
			neg_x_s2    <= neg_x_s1;
			neg_y_s2    <= neg_y_s1;
			is_mouse_s2 <= is_mouse_s1;
			is_joy_s2   <= is_joy_s1;
			dx_s2       <= dx_s1;
			dy_s2       <= dy_s1;
			kp_s2       <= kp_s1;
			mmask_s2    <= mmask_s1;
			jmask_s2    <= jmask_s1;
		end
	end

	// divide by ten via reciprocal, then restore the sign (truncates toward zero)
	logic [PROD_W+RECIP_W-1:0] qf_mx, qf_my, qf_ly;
	logic [MOVE_W-1:0]         q_mx, q_my, q_ly;
	logic signed [MOVE_W-1:0]  mv_mx, mv_my, mv_ly;

	assign qf_mx = {{RECIP_W{1'b0}}, prod_mx_s2} * {{PROD_W{1'b0}}, RECIP_K};
	assign qf_my = {{RECIP_W{1'b0}}, prod_my_s2} * {{PROD_W{1'b0}}, RECIP_K};
	assign qf_ly = {{RECIP_W{1'b0}}, prod_ly_s2} * {{PROD_W{1'b0}}, RECIP_K};
	assign q_mx  = {{(MOVE_W - QUOT_W){1'b0}}, qf_mx[RECIP_SHIFT +: QUOT_W]};
	assign q_my  = {{(MOVE_W - QUOT_W){1'b0}}, qf_my[RECIP_SHIFT +: QUOT_W]};
	assign q_ly  = {{(MOVE_W - QUOT_W){1'b0}}, qf_ly[RECIP_SHIFT +: QUOT_W]};
	assign mv_mx = neg_x_s2 ? -q_mx : q_mx;
	assign mv_my = neg_y_s2 ? -q_my : q_my;
	assign mv_ly = neg_y_s2 ? -q_ly : q_ly;

	// held values double as the result register
	logic signed [MOVE_W-1:0]  mouse_x_q, mouse_y_q, look_y_q;
	logic signed [DELTA_W-1:0] joy_x_q, joy_y_q;
	logic [MMASK_W-1:0]        mmask_q;
	logic [JMASK_W-1:0]        jmask_q;
	logic                      kp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mouse_x_q <= '0;
			mouse_y_q <= '0;
			look_y_q  <= '0;
			joy_x_q   <= '0;
			joy_y_q   <= '0;
		end else if (out_adv && s2_valid_q) begin
			if (is_mouse_s2) begin
				mouse_x_q <= mv_mx;
				mouse_y_q <= mv_my;
				look_y_q  <= mv_ly;
			end
			if (is_joy_s2) begin
				joy_x_q <= dx_s2;
				joy_y_q <= dy_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && s2_valid_q) begin
			mmask_q <= mmask_s2;
			jmask_q <= jmask_s2;
			kp_q    <= kp_s2;
		end
	end

	assign res.mouse_move_x      = mouse_x_q;
	assign res.mouse_move_y      = mouse_y_q;
	assign res.look_move_y       = look_y_q;
	assign res.joy_pos_x         = joy_x_q;
	assign res.joy_pos_y         = joy_y_q;
	assign res.mouse_double_mask = mmask_q;
	assign res.joy_double_mask   = jmask_q;
	assign res.key_pressed       = kp_q;

	// no event beat may land while the key store is still being cleared
	`IEMD_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, clearing, !accept,
		"event accepted during key store clear")

	// a full pipe behind a stalled result must hold off the input
	`IEMD_ASSERT_IMP(a_full_pipe_stalls, clk, arst_n,
		out_valid_q && !res.ready && s2_valid_q && s1_valid_q, !evt.ready,
		"input taken while pipeline full and stalled")

	// first mouse button mirror follows a key down on its code
	`IEMD_ASSERT_NEXT(a_btn_mirror, clk, arst_n,
		accept && evt_down && MOUSE_KEY_BASE < KEY_CODES &&
		32'(evt.key_code) == MOUSE_KEY_BASE, btn_down_q[0],
		"mouse button bit not set after key down")

endmodule

`default_nettype wire
